// ===== rtl/core/epds_pkg.sv =====
// ============================================================================
// epds_pkg - shared types and constants for the echo proximity drive selector
// Widths, reset values, register indexes and the config/result structs.
// ============================================================================
package epds_pkg;

    // Echo counter width and its saturation value
    localparam int COUNT_BITS = 16;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // Field widths
    localparam int LIMIT_BITS = 16;
    localparam int DUTY_BITS  = 10;
    localparam int STEP_BITS  = 26;
    localparam int MASK_BITS  = 3;

    // Configuration port widths
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 26;

    // Distance test: count * 17 < limit * 10 (count ticks of 1.7 mm)
    localparam int ECHO_NUM       = 17;
    localparam int LIMIT_DEN      = 10;
    localparam int NUM_BITS       = 5;
    localparam int DEN_BITS       = 4;
    localparam int SCALED_C_BITS  = COUNT_BITS + NUM_BITS;
    localparam int SCALED_L_BITS  = LIMIT_BITS + DEN_BITS;
    localparam int PROD_BITS      = (SCALED_C_BITS > SCALED_L_BITS) ?
                                    SCALED_C_BITS : SCALED_L_BITS;

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_SIDE_LIMIT  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_FRONT_LIMIT = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_DUTY_CLEAR  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_DUTY_SIDE   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_DUTY_FRONT  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_FRONT_STEP  = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_SIDE_STEP   = 3'd6;

    // Reset values
    localparam logic [LIMIT_BITS-1:0] RST_SIDE_LIMIT  = 16'd200;
    localparam logic [LIMIT_BITS-1:0] RST_FRONT_LIMIT = 16'd100;
    localparam logic [DUTY_BITS-1:0]  RST_DUTY_CLEAR  = 10'd800;
    localparam logic [DUTY_BITS-1:0]  RST_DUTY_SIDE   = 10'd600;
    localparam logic [DUTY_BITS-1:0]  RST_DUTY_FRONT  = 10'd0;
    localparam logic [STEP_BITS-1:0]  RST_FRONT_STEP  = 26'd589824;
    localparam logic [STEP_BITS-1:0]  RST_SIDE_STEP   = 26'd445644;
    localparam logic [STEP_BITS-1:0]  RST_HELD_STEP   = 26'd589824;

    // Near mask bit positions
    localparam int BIT_LEFT  = 2;
    localparam int BIT_RIGHT = 1;
    localparam int BIT_FRONT = 0;

    typedef struct packed {
        logic [LIMIT_BITS-1:0] side_limit_mm;
        logic [LIMIT_BITS-1:0] front_limit_mm;
        logic [DUTY_BITS-1:0]  duty_clear;
        logic [DUTY_BITS-1:0]  duty_side;
        logic [DUTY_BITS-1:0]  duty_front;
        logic [STEP_BITS-1:0]  front_tone_step;
        logic [STEP_BITS-1:0]  side_tone_step;
    } cfg_t;

    typedef struct packed {
        logic [MASK_BITS-1:0] near_mask;
        logic [DUTY_BITS-1:0] motor_duty;
        logic                 tone_on;
        logic [STEP_BITS-1:0] tone_step;
    } result_t;

endpackage

// ===== rtl/core/epds_ifs.sv =====
// ============================================================================
// epds_ifs - valid/ready channel interfaces of the drive selector
// Tick request channel, result channel and configuration write channel.
// ============================================================================
interface epds_tick_if;
    logic valid;
    logic ready;
    logic echo_left;
    logic echo_right;
    logic echo_front;

    modport source (output valid, echo_left, echo_right, echo_front, input ready);
    modport sink   (input valid, echo_left, echo_right, echo_front, output ready);
endinterface

interface epds_result_if;
    import epds_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [MASK_BITS-1:0] near_mask;
    logic [DUTY_BITS-1:0] motor_duty;
    logic                 tone_on;
    logic [STEP_BITS-1:0] tone_step;

    modport source (output valid, near_mask, motor_duty, tone_on, tone_step,
                    input ready);
    modport sink   (input valid, near_mask, motor_duty, tone_on, tone_step,
                    output ready);
endinterface

interface epds_cfg_if;
    import epds_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/epds_cfg_regs.sv =====
// ============================================================================
// epds_cfg_regs - configuration register file
// Accepts one write per cycle; indexes past the list are dropped.
// ============================================================================
module epds_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    epds_cfg_if.sink      cfg,
    output epds_pkg::cfg_t regs
);
    import epds_pkg::*;

    cfg_t regs_reg;
    cfg_t regs_next;

    // Always ready for a write
    assign cfg.ready = 1'b1;

    // Decode the write request
    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_SIDE_LIMIT:  regs_next.side_limit_mm   = cfg.data[LIMIT_BITS-1:0];
                REG_FRONT_LIMIT: regs_next.front_limit_mm  = cfg.data[LIMIT_BITS-1:0];
                REG_DUTY_CLEAR:  regs_next.duty_clear      = cfg.data[DUTY_BITS-1:0];
                REG_DUTY_SIDE:   regs_next.duty_side       = cfg.data[DUTY_BITS-1:0];
                REG_DUTY_FRONT:  regs_next.duty_front      = cfg.data[DUTY_BITS-1:0];
                REG_FRONT_STEP:  regs_next.front_tone_step = cfg.data[STEP_BITS-1:0];
                REG_SIDE_STEP:   regs_next.side_tone_step  = cfg.data[STEP_BITS-1:0];
                default:         regs_next = regs_reg;
            endcase
        end
    end

    // Hold the registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.side_limit_mm   <= RST_SIDE_LIMIT;
            regs_reg.front_limit_mm  <= RST_FRONT_LIMIT;
            regs_reg.duty_clear      <= RST_DUTY_CLEAR;
            regs_reg.duty_side       <= RST_DUTY_SIDE;
            regs_reg.duty_front      <= RST_DUTY_FRONT;
            regs_reg.front_tone_step <= RST_FRONT_STEP;
            regs_reg.side_tone_step  <= RST_SIDE_STEP;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

    assign regs = regs_reg;

endmodule

// ===== rtl/core/epds_channel.sv =====
// ============================================================================
// epds_channel - one sensor's echo counter and near flag
// Counts high ticks, saturating; at the falling edge compares the distance.
// ============================================================================
module epds_channel (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            take,
    input  logic                            level,
    input  logic [epds_pkg::LIMIT_BITS-1:0] limit,
    output logic                            flag
);
    import epds_pkg::*;

    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic                  flag_reg;
    logic                  flag_next;
    logic [PROD_BITS-1:0]  scaled_count;
    logic [PROD_BITS-1:0]  scaled_limit;

    // Scale both sides of the distance test
    assign scaled_count = PROD_BITS'(count_reg) * PROD_BITS'(ECHO_NUM);
    assign scaled_limit = PROD_BITS'(limit) * PROD_BITS'(LIMIT_DEN);

    // Advance the counter, latch the flag when a pulse ends
    always_comb
    begin
        flag_next = flag_reg;
        if (level)
        begin
            count_next = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;
        end
        else
        begin
            count_next = '0;
            if (count_reg != '0)
            begin
                flag_next = (scaled_count < scaled_limit);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            flag_reg  <= 1'b0;
        end
        else if (take)
        begin
            count_reg <= count_next;
            flag_reg  <= flag_next;
        end
    end

    assign flag = flag_next;

endmodule

// ===== rtl/core/epds_select.sv =====
// ============================================================================
// epds_select - priority drive and tone selection
// Front over sides; keeps the tone step while nothing is near.
// ============================================================================
module epds_select (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           take,
    input  logic [epds_pkg::MASK_BITS-1:0] near_mask,
    input  epds_pkg::cfg_t                 regs,
    output epds_pkg::result_t              res
);
    import epds_pkg::*;

    logic [STEP_BITS-1:0] held_step_reg;
    logic [STEP_BITS-1:0] held_step_next;
    logic                 side_near;

    assign side_near = near_mask[BIT_LEFT] | near_mask[BIT_RIGHT];

    // Pick duty, tone enable and step
    always_comb
    begin
        held_step_next = held_step_reg;
        res.near_mask  = near_mask;
        if (near_mask[BIT_FRONT])
        begin
            held_step_next = regs.front_tone_step;
            res.motor_duty = regs.duty_front;
            res.tone_on    = 1'b1;
        end
        else if (side_near)
        begin
            held_step_next = regs.side_tone_step;
            res.motor_duty = regs.duty_side;
            res.tone_on    = 1'b1;
        end
        else
        begin
            res.motor_duty = regs.duty_clear;
            res.tone_on    = 1'b0;
        end
        res.tone_step = held_step_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_step_reg <= RST_HELD_STEP;
        end
        else if (take)
        begin
            held_step_reg <= held_step_next;
        end
    end

endmodule

// ===== rtl/core/echo_proximity_drive_selector.sv =====
// ============================================================================
// echo_proximity_drive_selector - ultrasonic near detection and drive select
// Three echo counters with distance tests feed a front-first priority select.
// ============================================================================
//   channel | dir | payload
//   --------+-----+-----------------------------------------------
//   cfg     | in  | index[2:0], data[25:0] register write
//   tick    | in  | echo_left, echo_right, echo_front
//   result  | out | near_mask[2:0], motor_duty[9:0], tone_on, tone_step[25:0]
//
// One tick per cycle while tick.ready is high; a single output register behind
// the counter and select logic shows its result in the cycle after acceptance.
// tick.ready drops only while a result is held and result.ready is low.
// Reset loads the register defaults, clears counters and flags, and restores
// the held tone step; no clearing pass is needed.
module echo_proximity_drive_selector (
    input  logic          clk,
    input  logic          rst_n,
    epds_cfg_if.sink      cfg,
    epds_tick_if.sink     tick,
    epds_result_if.source result
);
    import epds_pkg::*;

    cfg_t                 regs;
    logic                 take;
    logic [MASK_BITS-1:0] near_mask;
    result_t              res;
    result_t              res_reg;
    logic                 res_valid_reg;
    logic                 res_valid_next;

    epds_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    // Accept a tick whenever the output slot is free or being drained
    assign tick.ready = !res_valid_reg || result.ready;
    assign take       = tick.valid && tick.ready;

    epds_channel u_left (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .level (tick.echo_left),
        .limit (regs.side_limit_mm),
        .flag  (near_mask[BIT_LEFT])
    );

    epds_channel u_right (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .level (tick.echo_right),
        .limit (regs.side_limit_mm),
        .flag  (near_mask[BIT_RIGHT])
    );

    epds_channel u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .level (tick.echo_front),
        .limit (regs.front_limit_mm),
        .flag  (near_mask[BIT_FRONT])
    );

    epds_select u_select (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .near_mask (near_mask),
        .regs      (regs),
        .res       (res)
    );

    // Hold the result until taken
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (take)
        begin
            res_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= res;
        end
    end

    assign result.valid      = res_valid_reg;
    assign result.near_mask  = res_reg.near_mask;
    assign result.motor_duty = res_reg.motor_duty;
    assign result.tone_on    = res_reg.tone_on;
    assign result.tone_step  = res_reg.tone_step;

`ifndef NO_ASSERTIONS
    // An accepted tick always produces a waiting result next cycle
    a_take_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> result.valid)
        else $error("accepted tick produced no result");

    // A stalled result blocks new ticks, so nothing is overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.ready) |-> !tick.ready)
        else $error("tick accepted over a stalled result");

    // Tone enable follows the near flags of the same result
    a_tone_matches_mask: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.tone_on == (result.near_mask != '0)))
        else $error("tone enable disagrees with near mask");
`endif

endmodule

// ===== dv/tb_echo_proximity_drive_selector.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_echo_proximity_drive_selector - self-checking bench for the drive selector
// Feeds echo ticks through the tick channel and programs the seven registers
// between phases. A cycle-level model of the counters, near flags and
// priority select predicts results not typed in the table, each compared field
// by field. A directed table comes first, then pulse-train phases under
// varying settings, and a long echo on the left and front sensors at the end.
// ============================================================================
module tb_echo_proximity_drive_selector;
    import epds_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 2;
    localparam int SETTLE       = 4;      // cycles after the last result
    localparam int STALL_LIMIT  = 2000;   // cycles with no handshake at all
    localparam int HOLD_CYCLES  = 60;     // long receiver hold-off
    localparam int MAX_REPORTS  = 10;
    localparam int LONG_TICKS   = 8;      // long pulse on left and front
    localparam int PULSE_CAP    = 100;

    localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 3'd7;

    typedef enum bit { ROW_TICK, ROW_REG } row_kind_t;

    typedef struct {
        row_kind_t                kind;
        logic [CFG_IDX_BITS-1:0]  idx;
        logic [CFG_DATA_BITS-1:0] data;
        logic [2:0]               echo;   // {left, right, front}
        bit                       typed;
        result_t                  want;
    } stim_row_t;

    // Results that can be read straight off the register settings
    localparam result_t NO_RES       = '0;
    localparam result_t RES_RESET    = {3'b000, RST_DUTY_CLEAR, 1'b0, RST_HELD_STEP};
    localparam result_t RES_FRONT    = {3'b001, RST_DUTY_FRONT, 1'b1, RST_FRONT_STEP};
    localparam result_t RES_SIDES    = {3'b110, RST_DUTY_SIDE, 1'b1, RST_SIDE_STEP};
    localparam result_t RES_HELD     = {3'b000, RST_DUTY_CLEAR, 1'b0, RST_SIDE_STEP};
    localparam result_t RES_DUTY_MAX = {3'b000, 10'd1023, 1'b0, RST_SIDE_STEP};

    localparam cfg_t REGS_FLOOR = '{
        side_limit_mm: 16'd0, front_limit_mm: 16'd0,
        duty_clear: 10'd1023, duty_side: 10'd0, duty_front: 10'd1023,
        front_tone_step: 26'h3FFFFFF, side_tone_step: 26'd0};
    localparam cfg_t REGS_CEIL = '{
        side_limit_mm: 16'hFFFF, front_limit_mm: 16'hFFFF,
        duty_clear: 10'd0, duty_side: 10'd1023, duty_front: 10'd0,
        front_tone_step: 26'd0, side_tone_step: 26'h3FFFFFF};

    localparam int DIR_ROWS = 23;
    stim_row_t dir_rows [DIR_ROWS] = '{
        '{ROW_TICK, REG_SIDE_LIMIT,  26'd0,        3'b000, 1'b1, RES_RESET},
        '{ROW_TICK, REG_SIDE_LIMIT,  26'd0,        3'b001, 1'b1, RES_RESET},
        '{ROW_TICK, REG_SIDE_LIMIT,  26'd0,        3'b001, 1'b1, RES_RESET},
        '{ROW_TICK, REG_SIDE_LIMIT,  26'd0,        3'b000, 1'b1, RES_FRONT},
        '{ROW_TICK, REG_SIDE_LIMIT,  26'd0,        3'b100, 1'b0, NO_RES},
        '{ROW_TICK, REG_SIDE_LIMIT,  26'd0,        3'b000, 1'b0, NO_RES},
        '{ROW_TICK, REG_SIDE_LIMIT,  26'd0,        3'b010, 1'b0, NO_RES},
        '{ROW_TICK, REG_SIDE_LIMIT,  26'd0,        3'b000, 1'b0, NO_RES},
        '{ROW_TICK, REG_SIDE_LIMIT,  26'd0,        3'b111, 1'b0, NO_RES},
        '{ROW_TICK, REG_SIDE_LIMIT,  26'd0,        3'b000, 1'b0, NO_RES},
        // zero front limit: any front pulse clears the front flag
        '{ROW_REG,  REG_FRONT_LIMIT, 26'd0,        3'b000, 1'b0, NO_RES},
        '{ROW_TICK, REG_SIDE_LIMIT,  26'd0,        3'b001, 1'b0, NO_RES},
        '{ROW_TICK, REG_SIDE_LIMIT,  26'd0,        3'b000, 1'b1, RES_SIDES},
        // zero side limit: nothing near, step keeps the side value
        '{ROW_REG,  REG_SIDE_LIMIT,  26'd0,        3'b000, 1'b0, NO_RES},
        '{ROW_TICK, REG_SIDE_LIMIT,  26'd0,        3'b110, 1'b0, NO_RES},
        '{ROW_TICK, REG_SIDE_LIMIT,  26'd0,        3'b000, 1'b1, RES_HELD},
        '{ROW_TICK, REG_SIDE_LIMIT,  26'd0,        3'b000, 1'b1, RES_HELD},
        // out-of-range index is dropped, wide data is cut to the field
        '{ROW_REG,  REG_UNUSED,      26'h3FFFFFF,  3'b000, 1'b0, NO_RES},
        '{ROW_REG,  REG_DUTY_CLEAR,  26'h3FFFFFF,  3'b000, 1'b0, NO_RES},
        '{ROW_TICK, REG_SIDE_LIMIT,  26'd0,        3'b000, 1'b1, RES_DUTY_MAX},
        '{ROW_REG,  REG_SIDE_LIMIT,  26'h3FFFFFF,  3'b000, 1'b0, NO_RES},
        '{ROW_TICK, REG_SIDE_LIMIT,  26'd0,        3'b100, 1'b0, NO_RES},
        '{ROW_TICK, REG_SIDE_LIMIT,  26'd0,        3'b000, 1'b0, NO_RES}
    };

    logic clk = 1'b0;
    logic rst_n;

    epds_tick_if   tick_bus ();
    epds_result_if result_bus ();
    epds_cfg_if    cfg_bus ();

    echo_proximity_drive_selector u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_bus),
        .tick   (tick_bus),
        .result (result_bus)
    );

    // Model state, indexed like the near mask: 2 left, 1 right, 0 front
    cfg_t                  regs;
    logic [COUNT_BITS-1:0] echo_cnt [3];
    logic [2:0]            near_flag;
    logic [STEP_BITS-1:0]  held_step;

    result_t     pending_drive_results [$];
    int unsigned mismatch_count = 0;
    int          snd_idle_pct;
    int          rcv_idle_pct;
    bit          hold_req = 1'b0;
    int          pulse_rem [3] = '{0, 0, 0};
    int          gap_rem [3]   = '{0, 0, 0};

    always #CLK_HALF clk = ~clk;

    // Advance the model by one tick and return the result it produces
    function automatic result_t predict_drive(input logic [2:0] echo);
        result_t               r;
        logic [LIMIT_BITS-1:0] lim;
        int                    ch;
        for (ch = 0; ch < 3; ch++)
        begin
            lim = (ch == BIT_FRONT) ? regs.front_limit_mm : regs.side_limit_mm;
            if (echo[ch])
            begin
                if (echo_cnt[ch] != COUNT_MAX)
                    echo_cnt[ch] = echo_cnt[ch] + 1'b1;
            end
            else
            begin
                // pulse ended: count ticks of 1.7 mm against the limit
                if (echo_cnt[ch] != '0)
                    near_flag[ch] = (32'(echo_cnt[ch]) * 32'd17) < (32'(lim) * 32'd10);
                echo_cnt[ch] = '0;
            end
        end
        if (near_flag[BIT_FRONT])
        begin
            held_step    = regs.front_tone_step;
            r.motor_duty = regs.duty_front;
            r.tone_on    = 1'b1;
        end
        else if (near_flag[BIT_LEFT] || near_flag[BIT_RIGHT])
        begin
            held_step    = regs.side_tone_step;
            r.motor_duty = regs.duty_side;
            r.tone_on    = 1'b1;
        end
        else
        begin
            r.motor_duty = regs.duty_clear;
            r.tone_on    = 1'b0;
        end
        r.near_mask = near_flag;
        r.tone_step = held_step;
        return r;
    endfunction

    // Mirror a register write into the model
    function automatic void apply_reg(input logic [CFG_IDX_BITS-1:0] idx,
                                      input logic [CFG_DATA_BITS-1:0] data);
        case (idx)
            REG_SIDE_LIMIT:  regs.side_limit_mm   = data[LIMIT_BITS-1:0];
            REG_FRONT_LIMIT: regs.front_limit_mm  = data[LIMIT_BITS-1:0];
            REG_DUTY_CLEAR:  regs.duty_clear      = data[DUTY_BITS-1:0];
            REG_DUTY_SIDE:   regs.duty_side       = data[DUTY_BITS-1:0];
            REG_DUTY_FRONT:  regs.duty_front      = data[DUTY_BITS-1:0];
            REG_FRONT_STEP:  regs.front_tone_step = data[STEP_BITS-1:0];
            REG_SIDE_STEP:   regs.side_tone_step  = data[STEP_BITS-1:0];
            default: ;
        endcase
    endfunction

    // Offer one tick request; called and returning at a falling edge
    task automatic send_tick(input logic [2:0] echo, input bit typed, input result_t want);
        result_t pred;
        while ($urandom_range(99) < snd_idle_pct)
        begin
            tick_bus.valid <= 1'b0;
            @(negedge clk);
        end
        tick_bus.valid      <= 1'b1;
        tick_bus.echo_left  <= echo[BIT_LEFT];
        tick_bus.echo_right <= echo[BIT_RIGHT];
        tick_bus.echo_front <= echo[BIT_FRONT];
        do
            @(posedge clk);
        while (!tick_bus.ready);
        pred = predict_drive(echo);
        pending_drive_results.push_back(typed ? want : pred);
        @(negedge clk);
    endtask

    // Write one register; the block is idle whenever this is called
    task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        apply_reg(idx, data);
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
        @(negedge clk);
    endtask

    // Program all registers, with junk above each limit and duty field
    task automatic program_regs(input cfg_t c);
        cfg_write(REG_SIDE_LIMIT,  {10'($urandom), c.side_limit_mm});
        cfg_write(REG_FRONT_LIMIT, {10'($urandom), c.front_limit_mm});
        cfg_write(REG_DUTY_CLEAR,  {16'($urandom), c.duty_clear});
        cfg_write(REG_DUTY_SIDE,   {16'($urandom), c.duty_side});
        cfg_write(REG_DUTY_FRONT,  {16'($urandom), c.duty_front});
        cfg_write(REG_FRONT_STEP,  c.front_tone_step);
        cfg_write(REG_SIDE_STEP,   c.side_tone_step);
    endtask

    // Stop offering and wait until every result is back
    task automatic drain();
        tick_bus.valid <= 1'b0;
        while (pending_drive_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // Echo pulse trains around the distance threshold, with some noise
    task automatic run_ticks(input int count);
        logic [2:0] echo;
        int         n;
        int         ch;
        int         span;
        for (n = 0; n < count; n++)
        begin
            if ($urandom_range(99) < 15)
                echo = 3'($urandom);
            else
            begin
                for (ch = 0; ch < 3; ch++)
                begin
                    if (pulse_rem[ch] > 0)
                    begin
                        echo[ch] = 1'b1;
                        pulse_rem[ch]--;
                    end
                    else if (gap_rem[ch] > 0)
                    begin
                        echo[ch] = 1'b0;
                        gap_rem[ch]--;
                    end
                    else
                    begin
                        // start a new pulse, length spread across the threshold
                        span = int'((ch == BIT_FRONT) ? regs.front_limit_mm
                                                      : regs.side_limit_mm) * 10 / 17;
                        span = 2 * span + 3;
                        if (span > PULSE_CAP)
                            span = PULSE_CAP;
                        pulse_rem[ch] = $urandom_range(span, 1) - 1;
                        gap_rem[ch]   = $urandom_range(5, 1);
                        echo[ch]      = 1'b1;
                    end
                end
            end
            send_tick(echo, 1'b0, NO_RES);
        end
    endtask

    // Result ready: random stalls, plus a long hold-off on request
    initial
    begin : result_sink
        int hold_left;
        hold_left        = 0;
        result_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                result_bus.ready <= 1'b0;
                hold_left--;
            end
            else
                result_bus.ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // Compare each result with the oldest prediction
    always @(posedge clk)
    begin : result_check
        result_t got;
        result_t want;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            got = {result_bus.near_mask, result_bus.motor_duty,
                   result_bus.tone_on, result_bus.tone_step};
            if (pending_drive_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: unexpected result mask=%b duty=%0d tone=%b step=%0d",
                             $realtime, got.near_mask, got.motor_duty, got.tone_on,
                             got.tone_step);
            end
            else
            begin
                want = pending_drive_results.pop_front();
                if (got.near_mask !== want.near_mask || got.motor_duty !== want.motor_duty ||
                    got.tone_on !== want.tone_on || got.tone_step !== want.tone_step)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: exp %b %0d %b %0d, got %b %0d %b %0d",
                                 $realtime, want.near_mask, want.motor_duty, want.tone_on,
                                 want.tone_step, got.near_mask, got.motor_duty,
                                 got.tone_on, got.tone_step);
                end
            end
        end
    end

    // End the run when no handshake completes for too long
    always @(posedge clk)
    begin : watchdog
        int quiet;
        if ((tick_bus.valid && tick_bus.ready) || (result_bus.valid && result_bus.ready) ||
            (cfg_bus.valid && cfg_bus.ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= STALL_LIMIT)
        begin
            $display("echo_proximity_drive_selector verification failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        cfg_t rnd;
        int   row;
        int   k;
        int   n;

        // Hold every input at a known value through reset
        rst_n               = 1'b0;
        tick_bus.valid      = 1'b0;
        tick_bus.echo_left  = 1'b0;
        tick_bus.echo_right = 1'b0;
        tick_bus.echo_front = 1'b0;
        cfg_bus.valid       = 1'b0;
        cfg_bus.index       = REG_SIDE_LIMIT;
        cfg_bus.data        = '0;
        snd_idle_pct        = 30;
        rcv_idle_pct        = 51;
        watchdog.quiet      = 0;

        regs = '{side_limit_mm: RST_SIDE_LIMIT, front_limit_mm: RST_FRONT_LIMIT,
                 duty_clear: RST_DUTY_CLEAR, duty_side: RST_DUTY_SIDE,
                 duty_front: RST_DUTY_FRONT, front_tone_step: RST_FRONT_STEP,
                 side_tone_step: RST_SIDE_STEP};
        for (k = 0; k < 3; k++)
            echo_cnt[k] = '0;
        near_flag = '0;
        held_step = RST_HELD_STEP;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // Walk the directed table
        for (row = 0; row < DIR_ROWS; row++)
        begin
            if (dir_rows[row].kind == ROW_REG)
            begin
                drain();
                cfg_write(dir_rows[row].idx, dir_rows[row].data);
            end
            else
                send_tick(dir_rows[row].echo, dir_rows[row].typed, dir_rows[row].want);
        end
        drain();

        // Extreme settings
        program_regs(REGS_FLOOR);
        run_ticks(50);
        drain();
        program_regs(REGS_CEIL);
        run_ticks(50);
        drain();

        // Random settings; swap the idle pattern, then run without idling
        for (k = 0; k < 4; k++)
        begin
            if (k == 1)
            begin
                snd_idle_pct = 51;
                rcv_idle_pct = 30;
            end
            else if (k == 3)
            begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            rnd.side_limit_mm   = 16'($urandom_range(120, 10));
            rnd.front_limit_mm  = 16'($urandom_range(120, 10));
            rnd.duty_clear      = 10'($urandom);
            rnd.duty_side       = 10'($urandom);
            rnd.duty_front      = 10'($urandom);
            rnd.front_tone_step = 26'($urandom);
            rnd.side_tone_step  = 26'($urandom);
            program_regs(rnd);
            // fill the block while the receiver holds off
            if (k == 2)
                hold_req = 1'b1;
            run_ticks(80);
            drain();
        end

        // Long left and front pulse after a near left pulse
        cfg_write(REG_SIDE_LIMIT, 26'h000FFFF);
        for (n = 0; n < 3; n++)
            send_tick(3'b100, 1'b0, NO_RES);
        send_tick(3'b000, 1'b0, NO_RES);
        for (n = 0; n < LONG_TICKS; n++)
            send_tick(3'b101, 1'b0, NO_RES);
        send_tick(3'b000, 1'b0, NO_RES);
        drain();

        if (mismatch_count == 0 && pending_drive_results.size() == 0)
            $display("echo_proximity_drive_selector verification clean");
        else
            $display("echo_proximity_drive_selector verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/epds_pkg.sv
rtl/core/epds_ifs.sv
rtl/core/epds_cfg_regs.sv
rtl/core/epds_channel.sv
rtl/core/epds_select.sv
rtl/core/echo_proximity_drive_selector.sv
dv/tb_echo_proximity_drive_selector.sv
